[src/cosine_similarity_assert.svh]
// Assertion macros used by the cosine similarity RTL.
`ifndef COSINE_SIMILARITY_ASSERT_SVH
`define COSINE_SIMILARITY_ASSERT_SVH

// Same-cycle implication, held off while reset is low.
`define CS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cosine similarity: implication check failed");

// Next-cycle implication, held off while reset is low.
`define CS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cosine similarity: next-cycle check failed");

`endif

[src/cs_pkg.sv]
// Package with widths, limits and types of the cosine similarity block.
package cs_pkg;
    localparam int ELEM_W            = 16;
    localparam int MAX_VECTOR_LENGTH = 4096;
    localparam int DOT_W             = 44;
    localparam int SQ_W              = 43;
    localparam int PROD_W            = 2 * SQ_W;
    localparam int QUO_W             = 33;
    localparam int REM_W             = PROD_W + QUO_W;
    localparam int ROOT_W            = QUO_W + 1;
    localparam int Q_DEPTH           = 2;

    // Saturation bound of the accumulators.
    localparam logic [SQ_W-1:0] SQ_LIMIT =
        SQ_W'(64'(MAX_VECTOR_LENGTH) << (2 * ELEM_W - 2));

    // Finished sums of one vector pair.
    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [SQ_W-1:0]         sa;
        logic [SQ_W-1:0]         sb;
    } t_sums;
endpackage

[src/cs_in_if.sv]
// Input channel interface: one element pair per transfer.
interface cs_in_if;
    import cs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     last_pair;
    modport source(output valid, elem_a, elem_b, last_pair, input ready);
    modport sink(input valid, elem_a, elem_b, last_pair, output ready);
endinterface

[src/cs_out_if.sv]
// Output channel interface: one similarity result per transfer.
interface cs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] similarity;
    logic               zero_norm;
    modport source(output valid, similarity, zero_norm, input ready);
    modport sink(input valid, similarity, zero_norm, output ready);
endinterface

[src/cs_front.sv]
// Front end: multiplies each element pair and accumulates the three sums.
module cs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cs_in_if.sink         i_in,
    input  logic          i_full,
    output logic          o_push,
    output cs_pkg::t_sums o_sums
);
    import cs_pkg::*;

    localparam logic signed [DOT_W:0] DOT_HI = (DOT_W+1)'(SQ_LIMIT);
    localparam logic signed [DOT_W:0] DOT_LO = -DOT_HI;

    logic                       r_s1_valid;
    logic                       r_s1_last;
    logic [2*ELEM_W-1:0]        r_pa;
    logic [2*ELEM_W-1:0]        r_pb;
    logic signed [2*ELEM_W-1:0] r_pab;
    logic signed [DOT_W-1:0]    r_dot;
    logic [SQ_W-1:0]            r_sa;
    logic [SQ_W-1:0]            r_sb;

    logic                       w_stall;
    logic signed [DOT_W:0]      w_dot_sum;
    logic [SQ_W:0]              w_sa_sum;
    logic [SQ_W:0]              w_sb_sum;
    t_sums                      w_next;

    // A finished vector waits in the product stage while the queue is full.
    assign w_stall    = r_s1_valid & r_s1_last & i_full;
    assign i_in.ready = ~w_stall;
    assign o_push     = r_s1_valid & r_s1_last & ~i_full;

    // Saturating accumulation.
    always_comb begin
        w_dot_sum = (DOT_W+1)'(r_dot) + (DOT_W+1)'(r_pab);
        w_sa_sum  = (SQ_W+1)'(r_sa) + (SQ_W+1)'(r_pa);
        w_sb_sum  = (SQ_W+1)'(r_sb) + (SQ_W+1)'(r_pb);
        if (w_dot_sum > DOT_HI) begin
            w_next.dot = DOT_W'(DOT_HI);
        end else if (w_dot_sum < DOT_LO) begin
            w_next.dot = DOT_W'(DOT_LO);
        end else begin
            w_next.dot = DOT_W'(w_dot_sum);
        end
        w_next.sa = (w_sa_sum > (SQ_W+1)'(SQ_LIMIT)) ? SQ_LIMIT : SQ_W'(w_sa_sum);
        w_next.sb = (w_sb_sum > (SQ_W+1)'(SQ_LIMIT)) ? SQ_LIMIT : SQ_W'(w_sb_sum);
    end

    assign o_sums = w_next;

    // Product stage and accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
            r_dot      <= '0;
            r_sa       <= '0;
            r_sb       <= '0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
                r_s1_last  <= i_in.last_pair;
                r_pa       <= unsigned'((2*ELEM_W)'(i_in.elem_a) * (2*ELEM_W)'(i_in.elem_a));
                r_pb       <= unsigned'((2*ELEM_W)'(i_in.elem_b) * (2*ELEM_W)'(i_in.elem_b));
                r_pab      <= (2*ELEM_W)'(i_in.elem_a) * (2*ELEM_W)'(i_in.elem_b);
            end
            if (r_s1_valid && !w_stall) begin
                if (r_s1_last) begin
                    r_dot <= '0;
                    r_sa  <= '0;
                    r_sb  <= '0;
                end else begin
                    r_dot <= w_next.dot;
                    r_sa  <= w_next.sa;
                    r_sb  <= w_next.sb;
                end
            end
        end
    end
endmodule

[src/cs_fifo.sv]
// Short queue of finished sums between the front and back ends.
module cs_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cs_pkg::t_sums i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output cs_pkg::t_sums o_data
);
    import cs_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_sums             r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr_ptr] <= i_data;
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

[src/cs_back.sv]
// Back end: serial products, restoring division and square root per vector.
`include "cosine_similarity_assert.svh"
module cs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cs_pkg::t_sums i_sums,
    output logic          o_pop,
    cs_out_if.source      o_out
);
    import cs_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_SQRT, S_OUT} t_state;

    t_state             r_state;
    logic [5:0]         r_cnt;
    logic [PROD_W-1:0]  r_mcand_a;
    logic [PROD_W-1:0]  r_mcand_d;
    logic [SQ_W-1:0]    r_mplier_b;
    logic [SQ_W-1:0]    r_mplier_d;
    logic [PROD_W-1:0]  r_prod;
    logic [PROD_W-1:0]  r_dsq;
    logic [REM_W-1:0]   r_rem;
    logic [REM_W-1:0]   r_div;
    logic [QUO_W-1:0]   r_quo;
    logic [ROOT_W-1:0]  r_num;
    logic [ROOT_W-1:0]  r_res;
    logic [ROOT_W-1:0]  r_bit;
    logic               r_neg;
    logic               r_out_valid;
    logic signed [15:0] r_sim;
    logic               r_zero;

    logic [SQ_W-1:0]    w_dabs;
    logic               w_ge;
    logic [ROOT_W-1:0]  w_trial;
    logic [ROOT_W-1:0]  w_res_n;
    logic [ROOT_W-1:0]  w_half;
    logic [16:0]        w_q;

    assign o_pop            = (r_state == S_IDLE) && i_valid;
    assign o_out.valid      = r_out_valid;
    assign o_out.similarity = r_sim;
    assign o_out.zero_norm  = r_zero;

    // Datapath helpers for the division and root steps.
    always_comb begin
        w_dabs  = i_sums.dot[DOT_W-1] ? SQ_W'(-i_sums.dot) : SQ_W'(i_sums.dot);
        w_ge    = (r_rem >= r_div);
        w_trial = r_res + r_bit;
        w_res_n = (r_num >= w_trial) ? ((r_res >> 1) + r_bit) : (r_res >> 1);
        w_half  = (w_res_n + 1'b1) >> 1;
        w_q     = (w_half > ROOT_W'(32768)) ? 17'd32768 : 17'(w_half);
    end

    // Sequencer with its datapath and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mcand_a  <= PROD_W'(i_sums.sa);
                        r_mplier_b <= i_sums.sb;
                        r_mcand_d  <= PROD_W'(w_dabs);
                        r_mplier_d <= w_dabs;
                        r_prod     <= '0;
                        r_dsq      <= '0;
                        r_neg      <= i_sums.dot[DOT_W-1];
                        r_cnt      <= 6'(SQ_W);
                        if (i_sums.sa == '0 || i_sums.sb == '0) begin
                            r_sim       <= '0;
                            r_zero      <= 1'b1;
                            r_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    if (r_cnt != '0) begin
                        if (r_mplier_b[0]) r_prod <= r_prod + r_mcand_a;
                        if (r_mplier_d[0]) r_dsq  <= r_dsq + r_mcand_d;
                        r_mcand_a  <= r_mcand_a << 1;
                        r_mcand_d  <= r_mcand_d << 1;
                        r_mplier_b <= r_mplier_b >> 1;
                        r_mplier_d <= r_mplier_d >> 1;
                        r_cnt      <= r_cnt - 1'b1;
                    end else begin
                        r_rem   <= REM_W'(r_dsq) << 32;
                        r_div   <= REM_W'(r_prod) << QUO_W;
                        r_quo   <= '0;
                        r_cnt   <= 6'(QUO_W);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_ge) r_rem <= r_rem - r_div;
                    r_div <= r_div >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 6'(QUO_W)) begin
                        // The quotient reaches past the clamp: cosine at full scale.
                        if (w_ge) begin
                            r_sim       <= r_neg ? 16'sh8000 : 16'sh7fff;
                            r_zero      <= 1'b0;
                            r_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end
                    end else begin
                        r_quo <= {r_quo[QUO_W-2:0], w_ge};
                        if (r_cnt == '0) begin
                            r_num   <= ROOT_W'({r_quo[QUO_W-2:0], w_ge});
                            r_res   <= '0;
                            r_bit   <= ROOT_W'(1) << (QUO_W - 1);
                            r_cnt   <= 6'((QUO_W - 1) / 2);
                            r_state <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    if (r_num >= w_trial) r_num <= r_num - w_trial;
                    r_res <= w_res_n;
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        if (r_neg) begin
                            r_sim <= signed'(16'(17'd0 - w_q));
                        end else begin
                            r_sim <= w_q[16:15] != 2'b00 ? 16'sh7fff : signed'(w_q[15:0]);
                        end
                        r_zero      <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Consistency checks on the sequencer and its results.
    `CS_ASSERT_IMPLY(a_pop_idle, i_clk, i_rst_n, o_pop, r_state == S_IDLE)
    `CS_ASSERT_IMPLY(a_zero_sim, i_clk, i_rst_n, r_out_valid && r_zero, r_sim == 16'sd0)
    `CS_ASSERT_IMPLY(a_pos_sign, i_clk, i_rst_n, r_out_valid && !r_neg, !r_sim[15])
    `CS_ASSERT_NEXT(a_out_state, i_clk, i_rst_n, r_out_valid && !o_out.ready, r_state == S_OUT)
endmodule

[src/cosine_similarity.sv]
// Top level of the streaming cosine similarity block.
// Usage: element pairs (elem_a, elem_b) of two vectors enter on i_in, one
// transfer per cycle while ready is high, with last_pair set on the final
// pair of each vector. The front end multiplies and accumulates in a
// two-stage pipeline and sustains one pair per cycle while ready is high.
// On the last pair the three saturated sums go to a two-entry queue and the
// accumulators clear, so the next vector may follow at once. The back end
// takes one vector at a time: once it pops the queue it runs shift-add
// multiplication and division setup, then restoring division, then square
// root, and then loads the output register. One result per
// vector then appears on o_out (similarity in Q1.15 and zero_norm) and holds
// until the receiver accepts it. While the receiver stalls, the queue fills
// and the front end lowers ready only when a further finished vector finds
// it full. A vector with an all-zero side skips the arithmetic: the idle
// state loads 0 with zero_norm set into the output register. Synchronous
// reset clears the sums, the queue and the output valid.
module cosine_similarity (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cs_in_if.sink    i_in,
    cs_out_if.source o_out
);
    import cs_pkg::*;

    logic  w_push;
    logic  w_full;
    logic  w_q_valid;
    logic  w_pop;
    t_sums w_sums_in;
    t_sums w_sums_out;

    cs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_sums  (w_sums_in)
    );

    cs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_sums_in),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_full),
        .o_data  (w_sums_out)
    );

    cs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_sums  (w_sums_out),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );
endmodule
